/* sv/lkl_pkg.sv */
`timescale 1ns / 1ps
// Package for the positional linked list: widths, command and status codes, sequencer states.
// Used by every module of the block and by its checker; depends on nothing.
package lkl_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 9;
  localparam int ACT_W        = 3;
  localparam int STAT_W       = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_GET     = 3'd2,
    ACT_FIND    = 3'd3,
    ACT_PRED    = 3'd4,
    ACT_SUCC    = 3'd5,
    ACT_REVERSE = 3'd6,
    ACT_CLEAR   = 3'd7
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_LOCATE,
    S_WALK,
    S_FETCH,
    S_FIND,
    S_REV,
    S_LINK,
    S_SPLICE
  } state_t;

endpackage

/* sv/lkl_node_mem.sv */
`timescale 1ns / 1ps
// Node store: value, forward link and backward link arrays, one shared read address.
// Each array has its own write port; read data is registered. Depends on lkl_pkg.
module lkl_node_mem import lkl_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic [$clog2(CAPACITY)-1:0] raddr,
  output logic [DATA_W-1:0]           rd_val,
  output logic [$clog2(CAPACITY):0]   rd_nxt,
  output logic [$clog2(CAPACITY):0]   rd_prv,
  input  logic                        val_we,
  input  logic [$clog2(CAPACITY)-1:0] val_waddr,
  input  logic [DATA_W-1:0]           val_wdata,
  input  logic                        nxt_we,
  input  logic [$clog2(CAPACITY)-1:0] nxt_waddr,
  input  logic [$clog2(CAPACITY):0]   nxt_wdata,
  input  logic                        prv_we,
  input  logic [$clog2(CAPACITY)-1:0] prv_waddr,
  input  logic [$clog2(CAPACITY):0]   prv_wdata
);

  localparam int LW = $clog2(CAPACITY) + 1;

  logic [DATA_W-1:0] val_mem [CAPACITY];
  logic [LW-1:0]     nxt_mem [CAPACITY];
  logic [LW-1:0]     prv_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (prv_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
    rd_val <= val_mem[raddr];
    rd_nxt <= nxt_mem[raddr];
    rd_prv <= prv_mem[raddr];
  end

endmodule

/* sv/lkl_free_mem.sv */
`timescale 1ns / 1ps
// Free node stack storage: one write port, one read port with registered data.
// Depends on lkl_pkg for the default capacity.
module lkl_free_mem import lkl_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(CAPACITY)-1:0] waddr,
  input  logic [$clog2(CAPACITY)-1:0] wdata,
  input  logic [$clog2(CAPACITY)-1:0] raddr,
  output logic [$clog2(CAPACITY)-1:0] rdata
);

  logic [$clog2(CAPACITY)-1:0] stack_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    rdata <= stack_mem[raddr];
  end

endmodule

/* sv/positional_doubly_linked_list.sv */
`timescale 1ns / 1ps
// Top level of the positional doubly linked list: command sequencer and list registers.
// Depends on lkl_pkg, lkl_node_mem and lkl_free_mem.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------------------
//   command  | in_action, in_position, in_value        | taken when start && !busy
//   result   | out_status, out_value_out,              | one cycle, marked by out_valid
//            | out_position_out, out_count             |
//
// Every item is latched in S_IDLE and then checked in S_CHECK. Items that walk the list
// (positional access, find, reverse) then visit the nodes in order; the walk is bound
// by the single read port of the node store, whose registered data gives the next link.
// Insert adds a locate step (S_LOCATE), two write steps (S_LINK, S_SPLICE) and, when a
// freed node is reused, a stack read step (S_ALLOC).
// Reset is synchronous and active low; it empties the list without touching the stores.
// The result is held for one cycle only; the receiver cannot stall it, and busy is low
// in that cycle so the next item may be taken at once.
module positional_doubly_linked_list import lkl_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACT_W-1:0]         in_action,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic [POS_W-1:0]         out_position_out,
  output logic [POS_W-1:0]         out_count
);

  // Node indexes take IW bits; a link takes one more so that CAPACITY can mark the end.
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // Compare width wide enough for both the position port and the element count, plus one.
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  state_t            state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [LW-1:0]     first_r, first_nxt;
  logic [LW-1:0]     last_r, last_nxt;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     p_r, p_nxt;
  logic [LW-1:0]     nx_r, nx_nxt;
  logic [LW-1:0]     node_r, node_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ftop_r, ftop_nxt;
  logic [CW-1:0]     fresh_r, fresh_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              ov_r, ov_nxt;
  status_t           st_r, st_nxt;
  logic [DATA_W-1:0] vo_r, vo_nxt;
  logic [POS_W-1:0]  po_r, po_nxt;

  // Node store ports.
  logic [IW-1:0]     raddr;
  logic [DATA_W-1:0] rd_val;
  logic [LW-1:0]     rd_nxt, rd_prv;
  logic              val_we, nxt_we, prv_we;
  logic [IW-1:0]     val_waddr, nxt_waddr, prv_waddr;
  logic [DATA_W-1:0] val_wdata;
  logic [LW-1:0]     nxt_wdata, prv_wdata;

  // Free stack ports.
  logic          sk_we;
  logic [IW-1:0] sk_waddr, sk_wdata, sk_raddr, sk_rdata;

  // Checks on the latched command.
  logic [PW-1:0] pos_x, cnt_x, tgt_x;
  logic          empty, full, ins_bad, acc_bad;
  status_t       chk_status;
  logic          walk_hit, find_hit, list_end;

  lkl_node_mem #(.CAPACITY(CAPACITY)) u_node_mem (
    .clk       (clk),
    .raddr     (raddr),
    .rd_val    (rd_val),
    .rd_nxt    (rd_nxt),
    .rd_prv    (rd_prv),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .nxt_we    (nxt_we),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .prv_we    (prv_we),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata)
  );

  lkl_free_mem #(.CAPACITY(CAPACITY)) u_free_mem (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  // Range and capacity checks. The check order follows the command's rules: for insert the
  // position is checked before fullness; for the access commands emptiness comes first.
  always_comb begin
    pos_x   = PW'(pos_r);
    cnt_x   = PW'(count_r);
    tgt_x   = (act_r == ACT_INSERT) ? (pos_x - 1'b1) : pos_x;
    empty   = (count_r == '0);
    full    = (cnt_x >= PW'(CAPACITY));
    ins_bad = (pos_x == '0) || (pos_x > (cnt_x + 1'b1));
    acc_bad = (pos_x == '0) || (pos_x > cnt_x);
    case (act_r)
      ACT_INSERT: begin
        if (ins_bad) begin
          chk_status = ST_RANGE;
        end else if (full || ((ftop_r == '0) && (PW'(fresh_r) >= PW'(CAPACITY)))) begin
          chk_status = ST_FULL;
        end else begin
          chk_status = ST_OK;
        end
      end
      ACT_REMOVE, ACT_GET: begin
        chk_status = empty ? ST_EMPTY : (acc_bad ? ST_RANGE : ST_OK);
      end
      ACT_PRED: begin
        chk_status = empty ? ST_EMPTY :
                     ((acc_bad || (pos_x == PW'(1))) ? ST_RANGE : ST_OK);
      end
      ACT_SUCC: begin
        chk_status = empty ? ST_EMPTY :
                     ((acc_bad || (pos_x == cnt_x)) ? ST_RANGE : ST_OK);
      end
      ACT_FIND: begin
        chk_status = empty ? ST_MISSING : ST_OK;
      end
      default: begin
        chk_status = ST_OK;
      end
    endcase
    // During a walk, the registered read data belongs to node cur_r at position idx_r.
    walk_hit = (PW'(idx_r) == tgt_x);
    find_hit = (rd_val == val_r);
    list_end = (idx_r == count_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_status != ST_OK) begin
          state_nxt = (act_r == ACT_FIND) ? S_IDLE : S_IDLE;
        end else begin
          case (act_r)
            ACT_INSERT:  state_nxt = (ftop_r != '0) ? S_ALLOC : S_LOCATE;
            ACT_FIND:    state_nxt = S_FIND;
            ACT_REVERSE: state_nxt = empty ? S_IDLE : S_REV;
            ACT_CLEAR:   state_nxt = S_IDLE;
            default:     state_nxt = S_WALK;
          endcase
        end
      end
      S_ALLOC: begin
        state_nxt = S_LOCATE;
      end
      S_LOCATE: begin
        state_nxt = (pos_x == PW'(1)) ? S_LINK : S_WALK;
      end
      S_WALK: begin
        if (walk_hit) begin
          case (act_r)
            ACT_INSERT:         state_nxt = S_LINK;
            ACT_REMOVE, ACT_GET: state_nxt = S_IDLE;
            default:            state_nxt = S_FETCH;
          endcase
        end
      end
      S_FETCH: begin
        state_nxt = S_IDLE;
      end
      S_FIND: begin
        if (find_hit || list_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_REV: begin
        if (list_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_LINK: begin
        state_nxt = S_SPLICE;
      end
      S_SPLICE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory controls and result. Reads and writes never hit the same entry in one
  // cycle: a walk only reads, reverse reads the node after the one it rewrites, and the
  // link updates of insert and remove touch nodes that are not read again in that item.
  always_comb begin
    act_nxt   = act_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    cur_nxt   = cur_r;
    p_nxt     = p_r;
    nx_nxt    = nx_r;
    node_nxt  = node_r;
    count_nxt = count_r;
    ftop_nxt  = ftop_r;
    fresh_nxt = fresh_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    st_nxt    = st_r;
    vo_nxt    = vo_r;
    po_nxt    = po_r;

    raddr     = cur_r[IW-1:0];
    val_we    = 1'b0;
    val_waddr = node_r[IW-1:0];
    val_wdata = val_r;
    nxt_we    = 1'b0;
    nxt_waddr = node_r[IW-1:0];
    nxt_wdata = nx_r;
    prv_we    = 1'b0;
    prv_waddr = node_r[IW-1:0];
    prv_wdata = p_r;
    sk_we     = 1'b0;
    sk_waddr  = ftop_r[IW-1:0];
    sk_wdata  = cur_r[IW-1:0];
    sk_raddr  = IW'(ftop_r - 1'b1);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = action_t'(in_action);
          pos_nxt = in_position;
          val_nxt = in_value;
          st_nxt  = ST_OK;
          vo_nxt  = '0;
          po_nxt  = '0;
        end
      end
      S_CHECK: begin
        if (chk_status != ST_OK) begin
          st_nxt = chk_status;
          ov_nxt = 1'b1;
        end else begin
          case (act_r)
            ACT_INSERT: begin
              if (ftop_r != '0) begin
                ftop_nxt = ftop_r - 1'b1;
              end else begin
                node_nxt  = LW'(fresh_r);
                fresh_nxt = fresh_r + 1'b1;
              end
            end
            ACT_CLEAR: begin
              first_nxt = NIL;
              last_nxt  = NIL;
              count_nxt = '0;
              ftop_nxt  = '0;
              fresh_nxt = '0;
              ov_nxt    = 1'b1;
            end
            ACT_REVERSE: begin
              raddr   = first_r[IW-1:0];
              cur_nxt = first_r;
              idx_nxt = CW'(1);
              if (empty) begin
                first_nxt = last_r;
                last_nxt  = first_r;
                ov_nxt    = 1'b1;
              end
            end
            default: begin
              raddr   = first_r[IW-1:0];
              cur_nxt = first_r;
              idx_nxt = CW'(1);
            end
          endcase
        end
      end
      S_ALLOC: begin
        node_nxt = LW'(sk_rdata);
      end
      S_LOCATE: begin
        if (pos_x == PW'(1)) begin
          p_nxt  = NIL;
          nx_nxt = first_r;
        end else begin
          raddr   = first_r[IW-1:0];
          cur_nxt = first_r;
          idx_nxt = CW'(1);
        end
      end
      S_WALK: begin
        if (!walk_hit) begin
          raddr   = rd_nxt[IW-1:0];
          cur_nxt = rd_nxt;
          idx_nxt = idx_r + 1'b1;
        end else begin
          case (act_r)
            ACT_INSERT: begin
              p_nxt  = cur_r;
              nx_nxt = rd_nxt;
            end
            ACT_REMOVE: begin
              vo_nxt = rd_val;
              if (rd_prv != NIL) begin
                nxt_we    = 1'b1;
                nxt_waddr = rd_prv[IW-1:0];
                nxt_wdata = rd_nxt;
              end else begin
                first_nxt = rd_nxt;
              end
              if (rd_nxt != NIL) begin
                prv_we    = 1'b1;
                prv_waddr = rd_nxt[IW-1:0];
                prv_wdata = rd_prv;
              end else begin
                last_nxt = rd_prv;
              end
              if (PW'(ftop_r) < PW'(CAPACITY)) begin
                sk_we    = 1'b1;
                ftop_nxt = ftop_r + 1'b1;
              end
              count_nxt = count_r - 1'b1;
              ov_nxt    = 1'b1;
            end
            ACT_GET: begin
              vo_nxt = rd_val;
              ov_nxt = 1'b1;
            end
            ACT_PRED: begin
              raddr = rd_prv[IW-1:0];
            end
            default: begin
              raddr = rd_nxt[IW-1:0];
            end
          endcase
        end
      end
      S_FETCH: begin
        vo_nxt = rd_val;
        ov_nxt = 1'b1;
      end
      S_FIND: begin
        if (find_hit) begin
          po_nxt = POS_W'(idx_r);
          ov_nxt = 1'b1;
        end else if (list_end) begin
          st_nxt = ST_MISSING;
          ov_nxt = 1'b1;
        end else begin
          raddr   = rd_nxt[IW-1:0];
          cur_nxt = rd_nxt;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_REV: begin
        // Swap the two links of this node while the read of the following node is issued.
        nxt_we    = 1'b1;
        nxt_waddr = cur_r[IW-1:0];
        nxt_wdata = rd_prv;
        prv_we    = 1'b1;
        prv_waddr = cur_r[IW-1:0];
        prv_wdata = rd_nxt;
        raddr     = rd_nxt[IW-1:0];
        cur_nxt   = rd_nxt;
        idx_nxt   = idx_r + 1'b1;
        if (list_end) begin
          first_nxt = last_r;
          last_nxt  = first_r;
          ov_nxt    = 1'b1;
        end
      end
      S_LINK: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      S_SPLICE: begin
        if (p_r != NIL) begin
          nxt_we    = 1'b1;
          nxt_waddr = p_r[IW-1:0];
          nxt_wdata = node_r;
        end else begin
          first_nxt = node_r;
        end
        if (nx_r != NIL) begin
          prv_we    = 1'b1;
          prv_waddr = nx_r[IW-1:0];
          prv_wdata = node_r;
        end else begin
          last_nxt = node_r;
        end
        count_nxt = count_r + 1'b1;
        ov_nxt    = 1'b1;
      end
      default: begin
        ov_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= NIL;
      last_r  <= NIL;
      count_r <= '0;
      ftop_r  <= '0;
      fresh_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
      ftop_r  <= ftop_nxt;
      fresh_r <= fresh_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    cur_r  <= cur_nxt;
    p_r    <= p_nxt;
    nx_r   <= nx_nxt;
    node_r <= node_nxt;
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
    vo_r   <= vo_nxt;
    po_r   <= po_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_value_out    = vo_r;
  assign out_position_out = po_r;
  assign out_count        = POS_W'(count_r);

endmodule

/* sv/lkl_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the positional linked list, bound to the top level.
// Depends on lkl_pkg for the status codes.
module lkl_checker import lkl_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [STAT_W-1:0]        out_status,
  input logic signed [DATA_W-1:0] out_value_out,
  input logic [POS_W-1:0]         out_position_out
);

  a_taken_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> ((out_value_out == '0) &&
                                              (out_position_out == '0)))
    else $error("failed command returned a nonzero value or position");

endmodule

bind positional_doubly_linked_list lkl_checker u_lkl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_value_out    (out_value_out),
  .out_position_out (out_position_out)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for positional_doubly_linked_list: directed and random command items.
// Depends on lkl_pkg and the block's RTL; the expected list is kept as an ordered queue.
module tb_top;
  import lkl_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int CYCLE_CAP  = 3000000;
  localparam int RAND_ITEMS = 1500;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         count;
  } list_reply_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [ACT_W-1:0]         in_action;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_value_out;
  logic [POS_W-1:0]         out_position_out;
  logic [POS_W-1:0]         out_count;

  // The expected contents of the list, front first, and the replies still owed.
  logic signed [DATA_W-1:0] shadow_list[$];
  list_reply_t              pending_replies[$];
  int                       fail_count;
  int                       mismatch_count;
  int                       cycle_count;

  positional_doubly_linked_list dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_position(in_position), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status), .out_value_out(out_value_out),
    .out_position_out(out_position_out), .out_count(out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow list and returns the reply the block must give.
  // Storage details such as the free stack never change a reply: with count below
  // capacity a node is always available, so the ordered queue is enough.
  function automatic list_reply_t list_command(action_t act, int pos,
                                                logic signed [DATA_W-1:0] val);
    list_reply_t r;
    int n;
    logic signed [DATA_W-1:0] flipped[$];
    r = '{status: ST_OK, value: '0, position: '0, count: '0};
    n = shadow_list.size();
    case (act)
      ACT_INSERT: begin
        if (pos < 1 || pos > n + 1) r.status = ST_RANGE;
        else if (n >= CAP) r.status = ST_FULL;
        else shadow_list.insert(pos - 1, val);
      end
      ACT_REMOVE: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (pos < 1 || pos > n) r.status = ST_RANGE;
        else begin
          r.value = shadow_list[pos - 1];
          shadow_list.delete(pos - 1);
        end
      end
      ACT_GET, ACT_PRED, ACT_SUCC: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (pos < 1 || pos > n) r.status = ST_RANGE;
        else if (act == ACT_PRED && pos == 1) r.status = ST_RANGE;
        else if (act == ACT_SUCC && pos == n) r.status = ST_RANGE;
        else if (act == ACT_GET) r.value = shadow_list[pos - 1];
        else if (act == ACT_PRED) r.value = shadow_list[pos - 2];
        else r.value = shadow_list[pos];
      end
      ACT_FIND: begin
        r.status = ST_MISSING;
        for (int i = 0; i < n; i++) begin
          if (shadow_list[i] == val) begin
            r.status = ST_OK;
            r.position = POS_W'(i + 1);
            break;
          end
        end
      end
      ACT_REVERSE: begin
        for (int i = n - 1; i >= 0; i--) flipped.push_back(shadow_list[i]);
        shadow_list = flipped;
      end
      default: shadow_list.delete();
    endcase
    r.count = POS_W'(shadow_list.size());
    return r;
  endfunction

  // Sends one item, waits for it to be taken, then, if gap is nonzero, lowers start and idles for the gap.
  // Start stays high across back-to-back items so it is never lowered and raised
  // in the same step.
  task automatic send_item(action_t act, int pos, logic signed [DATA_W-1:0] val, int gap);
    logic was_busy;
    start       <= 1'b1;
    in_action   <= act;
    in_position <= POS_W'(pos);
    in_value    <= val;
    forever begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
    end
    pending_replies.push_back(list_command(act, pos, val));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_gap(action_t act, int pos, logic signed [DATA_W-1:0] val);
    send_item(act, pos, val, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
  endtask

  // Waits until every owed reply has come, with the block's worst walk time after.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
  endtask

  // Replies are sampled at the falling edge, well away from the driving edge.
  always @(negedge clk) begin
    list_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        $display("unexpected reply: status %0d value %0d count %0d",
                 out_status, out_value_out, out_count);
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status || out_value_out !== want.value ||
            out_position_out !== want.position || out_count !== want.count) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: status %0d/%0d value %0d/%0d position %0d/%0d count %0d/%0d",
                     want.status, out_status, want.value, out_value_out,
                     want.position, out_position_out, want.count, out_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Every command on an empty list, plus inserts that fall outside the range.
  task automatic test_empty_list();
    send_random_gap(ACT_REMOVE, 1, 0);
    send_random_gap(ACT_GET, 1, 0);
    send_random_gap(ACT_PRED, 1, 0);
    send_random_gap(ACT_SUCC, 1, 0);
    send_random_gap(ACT_FIND, 0, 0);
    send_random_gap(ACT_REVERSE, 0, 0);
    send_random_gap(ACT_CLEAR, 0, 0);
    send_random_gap(ACT_INSERT, 0, 5);
    send_random_gap(ACT_INSERT, 2, 5);
  endtask

  // Extreme values and positions on a short list, each special case once.
  task automatic test_edges();
    send_random_gap(ACT_INSERT, 1, 32'sh7fffffff);
    send_random_gap(ACT_INSERT, 1, 32'sh80000000);
    send_random_gap(ACT_INSERT, 3, -1);
    send_random_gap(ACT_INSERT, 2, 0);
    send_random_gap(ACT_GET, 4, 0);
    send_random_gap(ACT_GET, 5, 0);
    send_random_gap(ACT_PRED, 1, 0);
    send_random_gap(ACT_PRED, 4, 0);
    send_random_gap(ACT_SUCC, 4, 0);
    send_random_gap(ACT_SUCC, 1, 0);
    send_random_gap(ACT_FIND, 0, -1);
    send_random_gap(ACT_FIND, 511, 12345);
    send_random_gap(ACT_REVERSE, 0, 0);
    send_random_gap(ACT_GET, 1, 0);
    send_random_gap(ACT_REMOVE, 0, 0);
    send_random_gap(ACT_REMOVE, 257, 0);
    send_random_gap(ACT_REMOVE, 2, 0);
    send_random_gap(ACT_CLEAR, 0, 0);
  endtask

  // Fills the list to capacity, hits the full case, and walks to the far end.
  task automatic test_full_list();
    for (int i = 0; i < CAP; i++) send_item(ACT_INSERT, i + 1, $urandom(), 0);
    send_random_gap(ACT_INSERT, 257, 7);
    send_random_gap(ACT_INSERT, 1, 7);
    send_random_gap(ACT_INSERT, 258, 7);
    send_random_gap(ACT_GET, 256, 0);
    send_random_gap(ACT_SUCC, 256, 0);
    send_random_gap(ACT_PRED, 256, 0);
    send_random_gap(ACT_FIND, 0, shadow_list[CAP - 1]);
    send_random_gap(ACT_REVERSE, 0, 0);
    send_random_gap(ACT_REMOVE, 256, 0);
    send_random_gap(ACT_REMOVE, 100, 0);
    // Freed nodes are reused from the stack here.
    send_random_gap(ACT_INSERT, 50, 1);
    send_random_gap(ACT_INSERT, 256, 2);
    send_random_gap(ACT_CLEAR, 0, 0);
  endtask

  // The sender holds off until the block has answered everything owed.
  task automatic test_pause();
    send_item(ACT_INSERT, 1, 42, 0);
    send_item(ACT_INSERT, 2, 43, 0);
    wait_drained();
    @(posedge clk);
    send_item(ACT_FIND, 0, 43, 0);
    send_item(ACT_REMOVE, 1, 0, 0);
  endtask

  // Mostly well-formed commands on a list of moderate length with values from a small
  // pool so that find hits, with some noise in position and value.
  task automatic test_random();
    logic signed [DATA_W-1:0] pool[8];
    action_t act;
    int n;
    int pos;
    int pick;
    logic signed [DATA_W-1:0] val;
    pool = '{32'sh80000000, 32'sh7fffffff, -1, 0, 1, 2, 77, -300};
    for (int k = 0; k < RAND_ITEMS; k++) begin
      n = shadow_list.size();
      pick = $urandom_range(0, 99);
      if (pick < 40 - (n > 48 ? 25 : 0)) act = ACT_INSERT;
      else if (pick < 60) act = ACT_REMOVE;
      else if (pick < 70) act = ACT_GET;
      else if (pick < 80) act = ACT_FIND;
      else if (pick < 87) act = ACT_PRED;
      else if (pick < 94) act = ACT_SUCC;
      else if (pick < 98) act = ACT_REVERSE;
      else act = ($urandom_range(0, 2) == 0) ? ACT_CLEAR : ACT_REVERSE;
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 511);
      else if (act == ACT_INSERT) pos = $urandom_range(1, n + 1);
      else pos = (n == 0) ? 1 : $urandom_range(1, n);
      val = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 7)] : $urandom();
      send_random_gap(act, pos, val);
    end
  endtask

  initial begin
    fail_count     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = ACT_INSERT;
    in_position = '0;
    in_value    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_edges();
    test_full_list();
    test_pause();
    test_random();
    wait_drained();
    if (pending_replies.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
